// ----- rtl/gsbc_pkg.sv -----
// Package with the beat types, constants and saturation helpers of the gyro bias calibrator.
package gsbc_pkg;

  // Number of still samples averaged into the bias (floor power of two is used).
  localparam int unsigned AvgCount = 64;
  localparam int unsigned AvgShift = $clog2(AvgCount + 1) - 1;

  localparam int unsigned RateW  = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned SumW   = 32;

  localparam logic [RateW-1:0] ThresholdReset = RateW'(100);

  typedef struct packed {
    logic                    mode;
    logic signed [RateW-1:0] rate_x;
    logic signed [RateW-1:0] rate_y;
    logic signed [RateW-1:0] rate_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [RateW-1:0] out_x;
    logic signed [RateW-1:0] out_y;
    logic signed [RateW-1:0] out_z;
    logic                    done_res;
  } out_beat_t;

  typedef enum logic {
    ModeCalibrate = 1'b0,
    ModeCorrect   = 1'b1
  } mode_e;

  // Saturate a 32-bit signed value to the 16-bit signed range.
  function automatic logic signed [RateW-1:0] sat_rate32(input logic signed [SumW-1:0] v);
    logic [SumW-RateW:0] top;
    top = v[SumW-1:RateW-1];
    if ((&top) || !(|top)) begin
      return v[RateW-1:0];
    end else if (v[SumW-1]) begin
      return {1'b1, {(RateW-1){1'b0}}};
    end else begin
      return {1'b0, {(RateW-1){1'b1}}};
    end
  endfunction

  // Saturate a 17-bit signed value to the 16-bit signed range.
  function automatic logic signed [RateW-1:0] sat_rate17(input logic signed [RateW:0] v);
    if (v[RateW] == v[RateW-1]) begin
      return v[RateW-1:0];
    end else if (v[RateW]) begin
      return {1'b1, {(RateW-1){1'b0}}};
    end else begin
      return {1'b0, {(RateW-1){1'b1}}};
    end
  endfunction

endpackage

// ----- rtl/gsbc_in_reg.sv -----
// Input register stage: captures one sample beat and holds it until the core can retire it.
module gsbc_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gsbc_pkg::in_beat_t in_beat_i,
  input  logic               advance_i,
  output logic               valid_o,
  output gsbc_pkg::in_beat_t beat_o
);

  logic               valid_q, valid_d;
  gsbc_pkg::in_beat_t beat_q;
  logic               load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= in_beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ----- rtl/gsbc_core.sv -----
// Calibration state, stillness detection, averaging and bias correction for one beat.
module gsbc_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gsbc_pkg::RateW-1:0]          cfg_data_i,
  input  logic                                fire_i,
  input  gsbc_pkg::in_beat_t                  beat_i,
  output gsbc_pkg::out_beat_t                 result_o
);

  localparam int unsigned RateW  = gsbc_pkg::RateW;
  localparam int unsigned CountW = gsbc_pkg::CountW;
  localparam int unsigned SumW   = gsbc_pkg::SumW;

  logic        [RateW-1:0]  threshold_q;
  logic        [CountW-1:0] count_q, count_d;
  logic signed [RateW-1:0]  ref_q  [3];
  logic signed [RateW-1:0]  ref_d  [3];
  logic signed [SumW-1:0]   sum_q  [3];
  logic signed [SumW-1:0]   sum_d  [3];
  logic signed [RateW-1:0]  bias_q [3];
  logic signed [RateW-1:0]  bias_d [3];

  logic signed [RateW-1:0]  rate      [3];
  logic signed [RateW:0]    diff      [3];
  logic        [RateW:0]    abs_diff  [3];
  logic signed [SumW:0]     sum_wide  [3];
  logic signed [SumW-1:0]   sum_sat   [3];
  logic signed [SumW-1:0]   sum_shift [3];
  logic signed [RateW:0]    corr_wide [3];
  logic signed [RateW-1:0]  corr      [3];
  logic        [2:0]        axis_still;
  logic                     still;
  logic                     done;
  logic                     calib;

  assign rate[0] = beat_i.rate_x;
  assign rate[1] = beat_i.rate_y;
  assign rate[2] = beat_i.rate_z;
  assign calib   = (gsbc_pkg::mode_e'(beat_i.mode) == gsbc_pkg::ModeCalibrate);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]       = {ref_q[i][RateW-1], ref_q[i]} - {rate[i][RateW-1], rate[i]};
      abs_diff[i]   = diff[i][RateW] ? (RateW + 1)'(-diff[i]) : diff[i];
      axis_still[i] = abs_diff[i] < {1'b0, threshold_q};

      sum_wide[i] = {sum_q[i][SumW-1], sum_q[i]} +
                    {{(SumW - RateW + 1){rate[i][RateW-1]}}, rate[i]};
      if (sum_wide[i][SumW] == sum_wide[i][SumW-1]) begin
        sum_sat[i] = sum_wide[i][SumW-1:0];
      end else if (sum_wide[i][SumW]) begin
        sum_sat[i] = {1'b1, {(SumW-1){1'b0}}};
      end else begin
        sum_sat[i] = {1'b0, {(SumW-1){1'b1}}};
      end

      corr_wide[i] = {rate[i][RateW-1], rate[i]} - {bias_q[i][RateW-1], bias_q[i]};
      corr[i]      = gsbc_pkg::sat_rate17(corr_wide[i]);
    end

    still = &axis_still;

    if (still) begin
      count_d = (&count_q) ? count_q : count_q + CountW'(1);
    end else begin
      count_d = '0;
    end

    done = count_d > CountW'(gsbc_pkg::AvgCount);

    for (int i = 0; i < 3; i++) begin
      sum_d[i]     = still ? sum_sat[i] : '0;
      ref_d[i]     = still ? ref_q[i] : rate[i];
      sum_shift[i] = sum_d[i] >>> gsbc_pkg::AvgShift;
      bias_d[i]    = done ? gsbc_pkg::sat_rate32(sum_shift[i]) : bias_q[i];
    end

    if (calib) begin
      result_o.out_x    = bias_d[0];
      result_o.out_y    = bias_d[1];
      result_o.out_z    = bias_d[2];
      result_o.done_res = done;
    end else begin
      result_o.out_x    = corr[0];
      result_o.out_y    = corr[1];
      result_o.out_z    = corr[2];
      result_o.done_res = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= gsbc_pkg::ThresholdReset;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < 3; i++) begin
        ref_q[i]  <= '0;
        sum_q[i]  <= '0;
        bias_q[i] <= '0;
      end
    end else if (fire_i && calib) begin
      count_q <= count_d;
      for (int i = 0; i < 3; i++) begin
        ref_q[i]  <= ref_d[i];
        sum_q[i]  <= sum_d[i];
        bias_q[i] <= bias_d[i];
      end
    end
  end

  // The counter only steps up by one, holds at its ceiling, or falls back to zero.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == '0 || count_q == $past(count_q) + CountW'(1)))
    else $error("still counter moved by something other than one step or a clear");

  // A finished average is only reported once enough still samples were seen.
  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && result_o.done_res) |-> (calib && count_d > CountW'(gsbc_pkg::AvgCount)))
    else $error("done reported without a full stillness window");

  // Correction beats leave the calibration state untouched.
  a_correct_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !calib) |=> ($stable(count_q) && $stable(bias_q[0]) &&
                            $stable(bias_q[1]) && $stable(bias_q[2])))
    else $error("correction beat changed the calibration state");

  // A moving sample always restarts the window with empty sums.
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && calib && !still) |=> (count_q == '0 && sum_q[0] == '0 &&
                                     sum_q[1] == '0 && sum_q[2] == '0))
    else $error("stillness window not cleared on motion");

endmodule

// ----- rtl/gsbc_out_reg.sv -----
// Result register stage: holds a finished result beat until the downstream side takes it.
module gsbc_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  gsbc_pkg::out_beat_t result_i,
  output logic                advance_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gsbc_pkg::out_beat_t out_beat_o
);

  logic                valid_q, valid_d;
  gsbc_pkg::out_beat_t beat_q;

  assign advance_o = !valid_q || !out_stall_i;
  assign valid_d   = fire_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      beat_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

endmodule

// ----- rtl/gyro_still_bias_calibrator_top.sv -----
// Top level of the gyro zero-rate bias calibrator: input register, core and result register.
//
// This block estimates and removes the zero-rate bias of a three-axis gyroscope. Each input
// beat carries a mode bit and three signed 16-bit rates. In calibrate mode a sample whose
// every axis differs from the stored reference by less than still_threshold counts as still:
// the stillness counter steps up (holding at its ceiling) and the sample is added to
// saturating 32-bit per-axis sums. Any other sample clears the counter and sums and becomes
// the new reference. Whenever the count exceeds AVG_COUNT, the bias is recomputed as each
// sum shifted right arithmetically by log2(AVG_COUNT), saturated to 16 bits, and done_res is
// set; the result beat carries the bias held after the step. In correct mode the result is
// the sample minus the stored bias, saturated, with done_res low, and no state changes.
// Every input beat gives exactly one result beat. The block takes one beat per clock cycle
// while in_stall_o is low. A result beat is offered once its input beat, held in the input
// register, has been passed by the single-pass core into the result register, which
// happens as soon as the result register is free or being emptied.
// The result register parts the two sides, so a new beat is taken while a finished result
// waits; the input stalls only when both registers are full and the output is stalled.
// still_threshold resets to 100 and is written through cfg_we_i and cfg_data_i; the user must
// write it only while the block is idle, which the block itself does not enforce.
module gyro_still_bias_calibrator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gsbc_pkg::RateW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  gsbc_pkg::in_beat_t          in_beat_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gsbc_pkg::out_beat_t         out_beat_o
);

  logic                advance;
  logic                stage_valid;
  logic                fire;
  gsbc_pkg::in_beat_t  stage_beat;
  gsbc_pkg::out_beat_t result;

  // A beat leaves the input register when the result register is free or being emptied.
  assign fire = stage_valid && advance;

  gsbc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .beat_o     (stage_beat)
  );

  gsbc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .beat_i     (stage_beat),
    .result_o   (result)
  );

  gsbc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .result_i    (result),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
